// File: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the pixel-to-Celsius converter
// Register indexes, calibration state codes, fixed-point limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    // Defaults of the top-level and root-cell parameters
    localparam int DEF_RAW_BITS      = 16;
    localparam int DEF_FRAC_BITS_OUT = 8;
    localparam int DEF_ROOT_W        = 2 * DEF_FRAC_BITS_OUT + 18;

    // Configuration port
    localparam int REG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_QUART = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTTER   = 3'd6;

    localparam logic [REG_W-1:0] RST_GAIN_C  = 48'd65536;
    localparam logic [7:0]       RST_BOARD   = 8'd25;
    localparam logic [15:0]      RST_SHUTTER = 16'd2500;

    // Kelvin conversion constants (hundredths of a degree)
    localparam int KELVIN_CENTI = 27315;
    localparam int TB_BIAS      = 2 * KELVIN_CENTI;
    localparam int TS_DIV       = 100;
    localparam int TB_DIV       = 200;

    // Magnitude limit of intermediate terms and the root argument ceiling
    localparam logic [60:0] LIM60   = 61'h1000_0000_0000_0000;
    localparam logic [51:0] ARG_MAX = 52'hF_FFFF_FFFF_FFFF;

    localparam int TEMP_W = 18;

    typedef enum logic [2:0] {
        CAL_IDLE,
        CAL_LOAD,
        CAL_MUL,
        CAL_RND,
        CAL_STORE,
        CAL_SUM
    } t_cal_state;

    typedef enum logic [2:0] {
        OP_TS,
        OP_TB,
        OP_TS2,
        OP_TS4,
        OP_TB2,
        OP_OFF,
        OP_G0,
        OP_G1
    } t_cal_op;

    typedef struct packed {
        logic               gain_neg;
        logic [60:0]        gain_mag;
        logic signed [61:0] offset;
    } t_cal_out;

    typedef struct packed {
        logic invalid;
        logic saturated;
    } t_pix_flags;

endpackage

`default_nettype wire

// File: rtl/thermal_pixel_to_celsius.sv
// ----------------------------------------------------------------------------
// thermal_pixel_to_celsius: raw thermal count to Celsius, fourth-root law
// From start to o_valid a pixel passes the front-end registers, both root chains and the output register.
// Throughput: one pixel per cycle while busy is low; the root chains take a new pixel each cycle.
// After reset and after every register write busy stays high while the shared
// serial multiplier rebuilds gain and offset.
// Reset is synchronous, active low; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermal_pixel_to_celsius #(
    parameter int RAW_BITS      = tpc_pkg::DEF_RAW_BITS,
    parameter int FRAC_BITS_OUT = tpc_pkg::DEF_FRAC_BITS_OUT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [RAW_BITS-1:0]                 i_raw_count,
    input  logic                                i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tpc_pkg::REG_W-1:0]           i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [tpc_pkg::TEMP_W-1:0]   o_temp_celsius_q8,
    output logic                                o_invalid,
    output logic                                o_saturated
);
    import tpc_pkg::*;

    // Radicand is the argument scaled so the fourth root lands in output units
    localparam int SHIFT = 4 * FRAC_BITS_OUT - 16;
    localparam int XW    = 4 * FRAC_BITS_OUT + 36;
    localparam int M1    = XW / 2;          // first square root: cells and bits
    localparam int M2    = M1 / 2;          // second square root
    localparam int PW    = 61 + RAW_BITS;
    localparam int TCW   = (M2 + 2 > TEMP_W + 1) ? M2 + 2 : TEMP_W + 1;
    localparam int KQ    = ((KELVIN_CENTI << FRAC_BITS_OUT) + 50) / 100;
    localparam int LAT   = 5 + M1 + M2;

    localparam logic signed [TCW-1:0] K_Q  = TCW'(KQ);
    localparam logic signed [TCW-1:0] T_HI = TCW'(2 ** (TEMP_W - 1) - 1);
    localparam logic signed [TCW-1:0] T_LO = TCW'(-(2 ** (TEMP_W - 1)));

    t_cal_out w_cal;
    logic     w_accept;

    assign w_accept = start && !busy;

    // Gain and offset derivation; holds busy while it runs
    tpc_calib u_calib (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (busy),
        .o_cal       (w_cal)
    );

    // Front end: capture, gain product, offset add, range check
    logic                r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic [RAW_BITS-1:0] r_a_raw;
    logic [PW-1:0]       r_b_prod;
    logic signed [62:0]  r_c_arg;
    logic [XW-1:0]       r_d_x;
    t_pix_flags          r_d_flags;

    logic [60:0]         c_mag;
    logic signed [62:0]  c_signed;
    logic                d_inv, d_sat;
    logic [51:0]         d_a;

    // Clamp |gain*raw| like every other product, then apply the sign
    assign c_mag    = (r_b_prod > PW'(LIM60)) ? LIM60 : r_b_prod[60:0];
    assign c_signed = w_cal.gain_neg ? -$signed({2'b00, c_mag}) : $signed({2'b00, c_mag});

    // Negative argument flags invalid and feeds zero; above Q36.16 clamps
    assign d_inv = r_c_arg[62];
    assign d_sat = !d_inv && (r_c_arg > $signed({11'b0, ARG_MAX}));
    assign d_a   = d_inv ? 52'd0 : (d_sat ? ARG_MAX : r_c_arg[51:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_raw             <= i_raw_count;
        r_b_prod            <= PW'(w_cal.gain_mag) * PW'(r_a_raw);
        r_c_arg             <= c_signed + 63'(w_cal.offset);
        r_d_x               <= XW'(d_a) << SHIFT;
        r_d_flags.invalid   <= d_inv;
        r_d_flags.saturated <= d_sat;
    end

    // Fourth root as two chained square roots: floor(sqrt(floor(sqrt(x))))
    logic [M1:0]       w1_valid;
    t_pix_flags        w1_flags [M1+1];
    logic [M1+2:0]     w1_rem   [M1+1];
    logic [M1-1:0]     w1_root  [M1+1];
    logic [XW-1:0]     w1_xsh   [M1+1];

    assign w1_valid[0] = r_d_valid;
    assign w1_flags[0] = r_d_flags;
    assign w1_rem[0]   = '0;
    assign w1_root[0]  = '0;
    assign w1_xsh[0]   = r_d_x;

    for (genvar k = 0; k < M1; k++) begin : g_chain1
        tpc_root_cell #(.ROOT_W(M1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w1_valid[k]),
            .i_flags (w1_flags[k]),
            .i_rem   (w1_rem[k]),
            .i_root  (w1_root[k]),
            .i_xsh   (w1_xsh[k]),
            .o_valid (w1_valid[k+1]),
            .o_flags (w1_flags[k+1]),
            .o_rem   (w1_rem[k+1]),
            .o_root  (w1_root[k+1]),
            .o_xsh   (w1_xsh[k+1])
        );
    end

    logic [M2:0]       w2_valid;
    t_pix_flags        w2_flags [M2+1];
    logic [M2+2:0]     w2_rem   [M2+1];
    logic [M2-1:0]     w2_root  [M2+1];
    logic [2*M2-1:0]   w2_xsh   [M2+1];

    assign w2_valid[0] = w1_valid[M1];
    assign w2_flags[0] = w1_flags[M1];
    assign w2_rem[0]   = '0;
    assign w2_root[0]  = '0;
    assign w2_xsh[0]   = w1_root[M1];

    for (genvar k = 0; k < M2; k++) begin : g_chain2
        tpc_root_cell #(.ROOT_W(M2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w2_valid[k]),
            .i_flags (w2_flags[k]),
            .i_rem   (w2_rem[k]),
            .i_root  (w2_root[k]),
            .i_xsh   (w2_xsh[k]),
            .o_valid (w2_valid[k+1]),
            .o_flags (w2_flags[k+1]),
            .o_rem   (w2_rem[k+1]),
            .o_root  (w2_root[k+1]),
            .o_xsh   (w2_xsh[k+1])
        );
    end

    // Output stage: subtract 273.15, clamp to the 18-bit range, zero invalid results
    logic signed [TCW-1:0]    t_full, t_clamp;
    logic                     r_o_valid, r_o_invalid, r_o_sat;
    logic signed [TEMP_W-1:0] r_o_temp;
    t_pix_flags               w_out_flags;

    assign w_out_flags = w2_flags[M2];
    assign t_full      = $signed(TCW'(w2_root[M2])) - K_Q;
    assign t_clamp     = (t_full > T_HI) ? T_HI : ((t_full < T_LO) ? T_LO : t_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w2_valid[M2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_temp    <= w_out_flags.invalid ? '0 : TEMP_W'(t_clamp);
        r_o_invalid <= w_out_flags.invalid;
        r_o_sat     <= w_out_flags.saturated;
    end

    assign o_valid           = r_o_valid;
    assign o_temp_celsius_q8 = r_o_temp;
    assign o_invalid         = r_o_invalid;
    assign o_saturated       = r_o_sat;

    // Every accepted pixel comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("pixel result missing at pipeline depth");

    // No result without a pixel accepted at the pipeline depth before
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result strobe without matching pixel");

    // Invalid results carry zero temperature and no saturation
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_temp_celsius_q8 == '0 && !o_saturated))
        else $error("invalid result with nonzero payload");

    // Outside reset, recalculation starts only from a register write
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(i_cfg_we))
        else $error("busy raised without a register write");

endmodule

`default_nettype wire

// File: rtl/tpc_root_cell.sv
// ----------------------------------------------------------------------------
// tpc_root_cell: one digit step of an integer square root
// Brings down two radicand bits, tries the next root bit, registers state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_root_cell #(
    parameter int ROOT_W = tpc_pkg::DEF_ROOT_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  tpc_pkg::t_pix_flags       i_flags,
    input  logic [ROOT_W+2:0]         i_rem,
    input  logic [ROOT_W-1:0]         i_root,
    input  logic [2*ROOT_W-1:0]       i_xsh,
    output logic                      o_valid,
    output tpc_pkg::t_pix_flags       o_flags,
    output logic [ROOT_W+2:0]         o_rem,
    output logic [ROOT_W-1:0]         o_root,
    output logic [2*ROOT_W-1:0]       o_xsh
);
    import tpc_pkg::*;

    logic              r_valid;
    t_pix_flags        r_flags;
    logic [ROOT_W+2:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [2*ROOT_W-1:0] r_xsh;

    logic [ROOT_W+2:0] w_rem2;
    logic [ROOT_W+2:0] w_trial;
    logic              w_ge;

    assign w_rem2  = {i_rem[ROOT_W:0], i_xsh[2*ROOT_W-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= i_flags;
        r_rem   <= w_ge ? (w_rem2 - w_trial) : w_rem2;
        r_root  <= {i_root[ROOT_W-2:0], w_ge};
        r_xsh   <= {i_xsh[2*ROOT_W-3:0], 2'b00};
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_xsh   = r_xsh;

endmodule

`default_nettype wire

// File: rtl/tpc_calib.sv
// ----------------------------------------------------------------------------
// tpc_calib: calibration registers and gain/offset sequencer
// Derives gain and offset from the coefficients with a shared bit-serial
// multiplier after reset and after every register write; the kelvin
// divisions run on the same multiplier as reciprocal products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_calib (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpc_pkg::REG_W-1:0]        i_cfg_wdata,
    output logic                             o_busy,
    output tpc_pkg::t_cal_out                o_cal
);
    import tpc_pkg::*;

    localparam int DIV_W     = 34;
    localparam int TK_W      = 26;
    localparam int CNT_W     = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(63);
    // ceil(2^41/100) == ceil(2^42/200); exact floor for numerators below 2^34
    localparam logic [63:0] KELVIN_RECIP = 64'd21990232556;

    function automatic logic [63:0] abs64(input logic signed [REG_W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[63] ? 64'(-e) : 64'(e);
    endfunction

    function automatic logic signed [61:0] clamp60(input logic signed [62:0] v);
        logic signed [62:0] lim;
        lim = $signed({2'b00, LIM60});
        if (v > lim) begin
            return 62'(lim);
        end else if (v < -lim) begin
            return 62'(-lim);
        end
        return 62'(v);
    endfunction

    // Configuration registers
    logic signed [REG_W-1:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [7:0]              r_bd;
    logic [15:0]             r_sh;

    // Sequencer
    t_cal_state       r_state, n_state;
    t_cal_op          r_op;
    logic [CNT_W-1:0] r_cnt;

    // Kelvin numerators
    logic [DIV_W-1:0] ts_num, tb_num;

    // Multiplier
    logic [63:0]  r_ma, r_mb, r_acc_hi, r_acc_lo, ld_a, ld_b;
    logic         r_neg, ld_neg;
    logic [64:0]  mul_sum;
    logic [6:0]   rnd_sh;
    logic [127:0] rnd_half;
    logic [127:0] rnd_q;
    logic [60:0]  rnd_mag;
    logic signed [61:0] rnd_res, r_res;

    // Derived terms
    logic [TK_W-1:0]    r_ts, r_tb;
    logic [35:0]        r_ts2, r_tb2;
    logic [55:0]        r_ts4;
    logic signed [61:0] r_moff, r_mg0, r_mg1;
    logic signed [62:0] sum_off, sum_gain;
    logic signed [61:0] cal_gain, r_offset;
    logic               r_gain_neg;
    logic [60:0]        r_gain_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= RST_GAIN_C;
            r_c3 <= '0;
            r_c4 <= '0;
            r_bd <= RST_BOARD;
            r_sh <= RST_SHUTTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_SQ:   r_c0 <= i_cfg_wdata;
                CFG_GAIN_LIN:  r_c1 <= i_cfg_wdata;
                CFG_GAIN_C:    r_c2 <= i_cfg_wdata;
                CFG_OFF_QUART: r_c3 <= i_cfg_wdata;
                CFG_OFF_C:     r_c4 <= i_cfg_wdata;
                CFG_BOARD:     r_bd <= i_cfg_wdata[7:0];
                CFG_SHUTTER:   r_sh <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Next state; any write restarts the derivation
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = CAL_LOAD;
        end else begin
            unique case (r_state)
                CAL_IDLE:  n_state = CAL_IDLE;
                CAL_LOAD:  n_state = CAL_MUL;
                CAL_MUL:   if (r_cnt == MUL_LAST) n_state = CAL_RND;
                CAL_RND:   n_state = CAL_STORE;
                CAL_STORE: n_state = (r_op == OP_G1) ? CAL_SUM : CAL_LOAD;
                CAL_SUM:   n_state = CAL_IDLE;
                default:   n_state = CAL_IDLE;
            endcase
        end
    end

    // Outputs of the sequencer
    always_comb begin
        o_busy = (r_state != CAL_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CAL_LOAD;
            r_op    <= OP_TS;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_op <= OP_TS;
            end else if (r_state == CAL_STORE && r_op != OP_G1) begin
                r_op <= t_cal_op'(r_op + 3'd1);
            end
            if (r_state == CAL_MUL) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Kelvin numerators, rounded on division
    assign ts_num = ((DIV_W'(r_sh) + DIV_W'(KELVIN_CENTI)) << 16) + DIV_W'(TS_DIV / 2);
    assign tb_num = ((DIV_W'(r_bd) * DIV_W'(100) + DIV_W'(r_sh) + DIV_W'(TB_BIAS)) << 16)
                    + DIV_W'(TB_DIV / 2);

    always_comb begin
        ld_a   = '0;
        ld_b   = '0;
        ld_neg = 1'b0;
        unique case (r_op)
            OP_TS: begin
                ld_a = 64'(ts_num);
                ld_b = KELVIN_RECIP;
            end
            OP_TB: begin
                ld_a = 64'(tb_num);
                ld_b = KELVIN_RECIP;
            end
            OP_TS2: begin
                ld_a = 64'(r_ts);
                ld_b = 64'(r_ts);
            end
            OP_TS4: begin
                ld_a = 64'(r_ts2);
                ld_b = 64'(r_ts2);
            end
            OP_TB2: begin
                ld_a = 64'(r_tb);
                ld_b = 64'(r_tb);
            end
            OP_OFF: begin
                ld_a   = abs64(r_c3);
                ld_b   = 64'(r_ts4);
                ld_neg = r_c3[REG_W-1];
            end
            OP_G0: begin
                ld_a   = abs64(r_c0);
                ld_b   = 64'(r_tb2);
                ld_neg = r_c0[REG_W-1];
            end
            OP_G1: begin
                ld_a   = abs64(r_c1);
                ld_b   = 64'(r_tb);
                ld_neg = r_c1[REG_W-1];
            end
            default: begin
            end
        endcase
    end

    assign mul_sum = {1'b0, r_acc_hi} + (r_ma[0] ? {1'b0, r_mb} : 65'd0);

    always_comb begin
        unique case (r_op)
            OP_TS:   rnd_sh = 7'd41;
            OP_TB:   rnd_sh = 7'd42;
            OP_OFF:  rnd_sh = 7'd40;
            OP_G0:   rnd_sh = 7'd32;
            OP_G1:   rnd_sh = 7'd24;
            default: rnd_sh = 7'd16;
        endcase
    end

    // Kelvin quotients truncate, their numerators already carry the half;
    // products round half away from zero on the magnitude, then clamp
    assign rnd_half = (r_op == OP_TS || r_op == OP_TB) ? 128'd0
                                                        : (128'd1 << (rnd_sh - 7'd1));
    assign rnd_q   = ({r_acc_hi, r_acc_lo} + rnd_half) >> rnd_sh;
    assign rnd_mag = (rnd_q > 128'(LIM60)) ? LIM60 : rnd_q[60:0];
    assign rnd_res = r_neg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

    assign sum_off  = 63'(r_moff) + 63'(r_c4);
    assign sum_gain = 63'(r_mg0) + 63'(r_mg1) + 63'(r_c2);
    assign cal_gain = clamp60(sum_gain);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CAL_LOAD: begin
                r_acc_hi <= '0;
                r_acc_lo <= '0;
                r_ma     <= ld_a;
                r_mb     <= ld_b;
                r_neg    <= ld_neg;
            end
            CAL_MUL: begin
                r_acc_hi <= mul_sum[64:1];
                r_acc_lo <= {mul_sum[0], r_acc_lo[63:1]};
                r_ma     <= r_ma >> 1;
            end
            CAL_RND: begin
                r_res <= rnd_res;
            end
            CAL_STORE: begin
                unique case (r_op)
                    OP_TS:   r_ts   <= r_res[TK_W-1:0];
                    OP_TB:   r_tb   <= r_res[TK_W-1:0];
                    OP_TS2:  r_ts2  <= r_res[35:0];
                    OP_TS4:  r_ts4  <= r_res[55:0];
                    OP_TB2:  r_tb2  <= r_res[35:0];
                    OP_OFF:  r_moff <= r_res;
                    OP_G0:   r_mg0  <= r_res;
                    OP_G1:   r_mg1  <= r_res;
                    default: begin
                    end
                endcase
            end
            CAL_SUM: begin
                r_offset   <= clamp60(sum_off);
                r_gain_neg <= cal_gain[61];
                r_gain_mag <= cal_gain[61] ? 61'(-cal_gain) : cal_gain[60:0];
            end
            default: begin
            end
        endcase
    end

    assign o_cal.gain_neg = r_gain_neg;
    assign o_cal.gain_mag = r_gain_mag;
    assign o_cal.offset   = r_offset;

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for thermal_pixel_to_celsius
// Drives raw pixel counts under many calibration settings and checks every
// converted temperature and its flags against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import tpc_pkg::*;

    localparam int RAW_W = DEF_RAW_BITS;
    localparam int NUM_REGS = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
    localparam int PIPE_LAT = 3 * DEF_FRAC_BITS_OUT + 32;
    localparam int CYCLE_LIMIT = 700000;
    localparam logic [63:0] MAG_LIMIT = 64'h1000_0000_0000_0000;
    localparam logic [63:0] ARG_CEIL = {12'd0, ARG_MAX};
    localparam longint KELVIN_Q8 = ((64'd27315 << DEF_FRAC_BITS_OUT) + 64'd50) / 64'd100;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     invalid;
        logic                     saturated;
    } t_pixel_temp;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [RAW_W-1:0]            i_raw_count = '0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [REG_W-1:0]            i_cfg_wdata = '0;
    logic                        o_valid;
    logic signed [TEMP_W-1:0]    o_temp_celsius_q8;
    logic                        o_invalid;
    logic                        o_saturated;

    // Model copy of the calibration registers and the queue of pending temperatures
    logic [REG_W-1:0] cal_regs [NUM_REGS];
    t_pixel_temp      pending_temps [$];

    int unsigned n_errors = 0;
    int unsigned n_pixels = 0;
    int unsigned n_checked = 0;
    int unsigned n_invalid = 0;
    int unsigned n_saturated = 0;
    int unsigned n_settings = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    thermal_pixel_to_celsius u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_raw_count       (i_raw_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_temp_celsius_q8 (o_temp_celsius_q8),
        .o_invalid         (o_invalid),
        .o_saturated       (o_saturated)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    function automatic logic signed [63:0] sext48(input logic [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

    function automatic logic signed [63:0] clamp_mag(input logic signed [63:0] v);
        if (v > $signed(MAG_LIMIT)) return MAG_LIMIT;
        if (v < -$signed(MAG_LIMIT)) return -$signed(MAG_LIMIT);
        return v;
    endfunction

    // (a*b) >> sh with the magnitude rounded half away from zero, held at 2^60
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic [63:0] b,
                                                         input int sh);
        logic [127:0] prod;
        logic [127:0] shifted;
        logic [63:0]  mag;
        logic [63:0]  r;
        logic         neg;
        neg = a[63];
        mag = neg ? -a : a;
        prod = {64'd0, mag} * {64'd0, b};
        if (sh > 0) begin
            prod = prod + (128'd1 << (sh - 1));
            shifted = prod >> sh;
            r = (shifted[127:64] != 0) ? MAG_LIMIT : shifted[63:0];
        end else begin
            r = (prod[127:64] != 0) ? MAG_LIMIT : prod[63:0];
        end
        if (r > MAG_LIMIT) r = MAG_LIMIT;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [63:0] fourth_root(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [63:0]  sq;
        logic [127:0] quad;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = c * c;
            quad = {64'd0, sq} * {64'd0, sq};
            if (quad <= x) r = c;
        end
        return r;
    endfunction

    function automatic t_pixel_temp celsius_of_pixel(input logic [RAW_W-1:0] raw);
        t_pixel_temp        res;
        logic [63:0]        shut;
        logic [63:0]        board;
        logic [63:0]        ts;
        logic [63:0]        tb;
        logic signed [63:0] ts2;
        logic signed [63:0] ts4;
        logic signed [63:0] tb2;
        logic signed [63:0] offset;
        logic signed [63:0] gain;
        logic signed [63:0] arg;
        logic [63:0]        a;
        logic signed [63:0] t;
        shut = {48'd0, cal_regs[CFG_SHUTTER][15:0]};
        board = {56'd0, cal_regs[CFG_BOARD][7:0]};
        ts = ((shut + 64'd27315) * 64'd65536 + 64'd50) / 64'd100;
        tb = ((64'd100 * board + shut + 64'd54630) * 64'd65536 + 64'd100) / 64'd200;
        ts2 = scaled_product(ts, ts, 16);
        ts4 = scaled_product(ts2, ts2, 16);
        tb2 = scaled_product(tb, tb, 16);
        offset = clamp_mag(scaled_product(sext48(cal_regs[CFG_OFF_QUART]), ts4, 40)
                           + sext48(cal_regs[CFG_OFF_C]));
        gain = clamp_mag(scaled_product(sext48(cal_regs[CFG_GAIN_SQ]), tb2, 32)
                         + scaled_product(sext48(cal_regs[CFG_GAIN_LIN]), tb, 24)
                         + sext48(cal_regs[CFG_GAIN_C]));
        arg = scaled_product(gain, {48'd0, raw}, 0) + offset;
        res = '0;
        if (arg < 0) begin
            res.invalid = 1'b1;
            return res;
        end
        a = arg;
        if (a > ARG_CEIL) begin
            a = ARG_CEIL;
            res.saturated = 1'b1;
        end
        t = $signed(fourth_root({64'd0, a} << (4 * DEF_FRAC_BITS_OUT - 16))) - KELVIN_Q8;
        if (t > 131071) t = 131071;
        if (t < -131072) t = -131072;
        res.temp = t[TEMP_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted transfer, check every result strobe
    // ------------------------------------------------------------------------

    initial begin
        cal_regs[CFG_GAIN_SQ]   = '0;
        cal_regs[CFG_GAIN_LIN]  = '0;
        cal_regs[CFG_GAIN_C]    = RST_GAIN_C;
        cal_regs[CFG_OFF_QUART] = '0;
        cal_regs[CFG_OFF_C]     = '0;
        cal_regs[CFG_BOARD]     = {40'd0, RST_BOARD};
        cal_regs[CFG_SHUTTER]   = {32'd0, RST_SHUTTER};
    end

    always @(posedge i_clk) begin
        t_pixel_temp want;
        if (i_rst_n) begin
            // Predict with the settings in force before any write at this edge
            if (start && !busy) begin
                pending_temps.push_back(celsius_of_pixel(i_raw_count));
                n_pixels++;
            end
            if (o_valid) begin
                if (pending_temps.size() == 0) begin
                    $display("%0t: result with nothing pending: temp %0d inv %0b sat %0b",
                             $time, o_temp_celsius_q8, o_invalid, o_saturated);
                    n_errors++;
                end else begin
                    want = pending_temps.pop_front();
                    n_checked++;
                    if (want.invalid) n_invalid++;
                    if (want.saturated) n_saturated++;
                    if (o_temp_celsius_q8 !== want.temp) begin
                        $display("%0t: temp mismatch: expected %0d, actual %0d",
                                 $time, want.temp, o_temp_celsius_q8);
                        n_errors++;
                    end
                    if (o_invalid !== want.invalid) begin
                        $display("%0t: invalid mismatch: expected %0b, actual %0b",
                                 $time, want.invalid, o_invalid);
                        n_errors++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                                 $time, want.saturated, o_saturated);
                        n_errors++;
                    end
                end
            end
            // Track register writes after the prediction above
            if (i_cfg_we && i_cfg_idx < NUM_REGS) begin
                case (i_cfg_idx)
                    CFG_BOARD:   cal_regs[i_cfg_idx] = {40'd0, i_cfg_wdata[7:0]};
                    CFG_SHUTTER: cal_regs[i_cfg_idx] = {32'd0, i_cfg_wdata[15:0]};
                    default:     cal_regs[i_cfg_idx] = i_cfg_wdata;
                endcase
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_temps.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (no_idle || sel < 11) return 0;
        if (sel < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start until the block takes the transfer, then maybe idle
    task automatic send_pixel(input logic [RAW_W-1:0] raw);
        int gap;
        start <= 1'b1;
        i_raw_count <= raw;
        do @(posedge i_clk); while (busy);
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all pending results, let the pipe settle, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_temps.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic load_calibration(input logic [REG_W-1:0] c0, input logic [REG_W-1:0] c1,
                                    input logic [REG_W-1:0] c2, input logic [REG_W-1:0] c3,
                                    input logic [REG_W-1:0] c4, input logic [7:0] bd,
                                    input logic [15:0] sh);
        write_reg(CFG_GAIN_SQ, c0);
        write_reg(CFG_GAIN_LIN, c1);
        write_reg(CFG_GAIN_C, c2);
        write_reg(CFG_OFF_QUART, c3);
        write_reg(CFG_OFF_C, c4);
        write_reg(CFG_BOARD, {40'd0, bd});
        write_reg(CFG_SHUTTER, {32'd0, sh});
    endtask

    function automatic logic [REG_W-1:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    function automatic logic [REG_W-1:0] rand_signed(input int bits);
        logic signed [63:0] v;
        v = $signed({$urandom(), $urandom()}) >>> (64 - bits);
        return v[REG_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset calibration is unity gain: the argument is raw in Q16
    task automatic test_reset_defaults();
        send_pixel('0);
        send_pixel(16'd1);
        send_pixel(16'd2);
        send_pixel(16'h8000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
    endtask

    task automatic test_special_cases();
        // Write to the spare index must change nothing
        write_reg(CFG_SPARE, 48'hFFFF_FFFF_FFFF);
        send_pixel('0);
        send_pixel(16'd1000);
        // Negative argument from a negative offset
        write_reg(CFG_OFF_C, 48'hFFFF_FFFF_0000);
        send_pixel('0);
        send_pixel(16'hFFFF);
        // Huge gain pushes the argument past its ceiling
        write_reg(CFG_GAIN_C, 48'h7FFF_FFFF_FFFF);
        send_pixel(16'd1);
        send_pixel(16'hFFFF);
        send_pixel('0);
        // Zero argument at zero gain and offset
        load_calibration('0, '0, '0, '0, '0, 8'd0, 16'd0);
        send_pixel(16'h1234);
    endtask

    task automatic test_register_extremes();
        no_idle = 1'b1;
        load_calibration(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                         48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 8'hFF, 16'hFFFF);
        send_pixel('0);
        send_pixel(16'hFFFF);
        load_calibration(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                         48'h8000_0000_0000, 48'h8000_0000_0000, 8'h00, 16'h0000);
        send_pixel('0);
        send_pixel(16'hFFFF);
        load_calibration(48'd100, 48'hFFFF_FFFF_F000, 48'd3000, 48'd5000,
                         48'd70000, 8'hFF, 16'd0);
        send_pixel('0);
        send_pixel(16'hFFFF);
        no_idle = 1'b0;
    endtask

    // Random settings, each followed by a burst of random pixels
    task automatic test_random_pixels(input int total);
        int sent;
        int burst;
        int style;
        sent = 0;
        while (sent < total) begin
            style = $urandom_range(0, 5);
            if (style == 0) begin
                load_calibration(rand48(), rand48(), rand48(), rand48(), rand48(),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end else begin
                // Plausible sensor calibration: mostly valid temperatures
                load_calibration(rand_signed(22), rand_signed(26),
                                 {24'd0, 24'($urandom_range(1, 24'hFF_FFFF))},
                                 rand_signed(32), rand_signed(34),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(80, 180);
            for (int i = 0; i < burst && sent < total; i++) begin
                send_pixel($urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 255))
                                                     : 16'($urandom_range(0, 65535)));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        // Hold reset at the start, then release for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_register_extremes();
        test_random_pixels(1950);

        start <= 1'b0;
        while (pending_temps.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);

        $display("Converted %0d pixels, checked %0d (%0d invalid, %0d clamped),",
                 n_pixels, n_checked, n_invalid, n_saturated);
        $display("over %0d register writes; %0d mismatches.", n_settings, n_errors);
        if (n_errors == 0 && pending_temps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/tpc_pkg.sv
rtl/tpc_root_cell.sv
rtl/tpc_calib.sv
rtl/thermal_pixel_to_celsius.sv
bench/tb.sv
